FILE: rtl/wcm_pkg.sv
package wcm_pkg;

   // item command codes
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   // register indexes on the csr port
   localparam int CSR_INDEX_W = 3;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODIFIER_FLAGS    = 3'd0,
      CSR_START_OFFSET      = 3'd1,
      CSR_RELATIVE_DISTANCE = 3'd2,
      CSR_DEPTH_LIMIT       = 3'd3,
      CSR_WITHIN_LIMIT      = 3'd4,
      CSR_PATTERN_LENGTH    = 3'd5
   } csr_index_type;

   localparam int CSR_DATA_W = 12;

   // bit positions in modifier_flags
   localparam int FLAG_OFFSET   = 0;
   localparam int FLAG_DISTANCE = 1;
   localparam int FLAG_DEPTH    = 2;
   localparam int FLAG_WITHIN   = 3;
   localparam int FLAG_NOCASE   = 4;

   localparam int FLAGS_W  = 5;
   localparam int POS12_W  = 12;
   localparam int PLEN_W   = 6;

   typedef struct packed {
      logic               cmd;
      logic [7:0]         data_byte;
      logic               last;
      logic [POS12_W-1:0] cursor_in;
   } req_type;

   typedef struct packed {
      logic               matched;
      logic [POS12_W-1:0] cursor_out;
   } rsp_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic load_we;
      logic shift;
      logic tail;
      logic active;
      logic nocase;
   } cell_ctrl_type;

endpackage

FILE: rtl/wcm_cell.sv
module wcm_cell (
   input  logic                   clock,
   input  wcm_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             din,
   input  logic [7:0]             nbr,
   output logic [7:0]             wout,
   output logic                   eq
);
   import wcm_pkg::*;

   logic [7:0] pat_ff;
   logic [7:0] win_ff;
   logic [7:0] pat_cmp;
   logic [7:0] win_cmp;

   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   always_ff @(posedge clock) begin
      if (ctrl.load_we) begin
         pat_ff <= din;
      end
      // the tail cell takes the new byte, the others take their neighbor's
      if (ctrl.shift) begin
         win_ff <= ctrl.tail ? din : nbr;
      end
   end

   always_comb begin
      pat_cmp = ctrl.nocase ? fold(pat_ff) : pat_ff;
      win_cmp = ctrl.nocase ? fold(win_ff) : win_ff;
      eq      = !ctrl.active || (pat_cmp == win_cmp);
   end

   assign wout = win_ff;

endmodule

FILE: rtl/windowed_content_matcher.sv
// Result path: the final payload item is registered in the compare stage, then in the output
// register that drives rsp_valid.
// Throughput: one item (pattern load or payload byte) per cycle; ready drops only while
// a final payload item in the compare stage waits behind a full output register.
// Match is a row of MAX_PATTERN byte cells shifting once per payload byte up to MAX_PAYLOAD.
// Reset (synchronous) clears config, cursor, position, window bounds and valids, not cell bytes.
module windowed_content_matcher #(
   parameter int MAX_PATTERN = 32,
   parameter int MAX_PAYLOAD = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  wcm_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output wcm_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wcm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wcm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import wcm_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
   localparam int CW    = ((POS_W > 13) ? POS_W : 13) + 1;
   localparam int LW9   = ((LEN_W > PLEN_W) ? LEN_W : PLEN_W) + 1;

   // configuration registers
   logic [FLAGS_W-1:0] flags_ff;
   logic [POS12_W-1:0] offset_ff;
   logic [POS12_W-1:0] dist_ff;
   logic [POS12_W-1:0] depth_ff;
   logic [POS12_W-1:0] within_ff;
   logic [PLEN_W-1:0]  plen_ff;

   // stage A state
   logic [LEN_W-1:0]   load_idx_ff, load_idx_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   ws_ff, ws_in;
   logic [POS_W-1:0]   we_ff, we_in;
   logic [POS12_W-1:0] pc_ff, pc_in;

   // stage B (compare) state
   logic               b_valid_ff, b_valid_in;
   logic               b_last_ff, b_last_in;
   logic               b_first_ff, b_first_in;
   logic               b_check_ff, b_check_in;
   logic [POS_W-1:0]   b_endpos_ff, b_endpos_in;
   logic               mf_ff, mf_in;
   logic [POS_W-1:0]   me_ff, me_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   logic               stall;
   logic               accept;
   logic               load_go;
   logic               pay_go;
   logic               shift_go;
   logic [LEN_W-1:0]   eff_len;
   logic [CW-1:0]      cur_x;
   logic [CW-1:0]      s_raw;
   logic [CW-1:0]      s_clip;
   logic [CW-1:0]      d_end;
   logic [CW-1:0]      w_end;
   logic [CW-1:0]      e_sel;
   logic               all_eq;
   logic               win_ok;
   logic               hit;
   logic               mf_eff;
   logic [POS_W-1:0]   me_eff;
   logic [CW-1:0]      lo_bound;

   logic [MAX_PATTERN-1:0] eq_vec;
   logic [7:0]             win_byte [MAX_PATTERN];

   function automatic logic [CW-1:0] clip(input logic [CW-1:0] v);
      return (v > CW'(MAX_PAYLOAD)) ? CW'(MAX_PAYLOAD) : v;
   endfunction

   // handshakes
   assign stall     = b_valid_ff && b_last_ff && rsp_valid_ff && !rsp_ready;
   assign req_ready = !stall;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign load_go   = accept && (req_payload.cmd == CMD_LOAD);
   assign pay_go    = accept && (req_payload.cmd == CMD_PAYLOAD);
   assign shift_go  = pay_go && (pos_ff < POS_W'(MAX_PAYLOAD));

   always_comb begin
      if (LW9'(plen_ff) > LW9'(MAX_PATTERN)) begin
         eff_len = LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = LEN_W'(plen_ff);
      end
   end

   // window bounds, taken on the first payload byte
   always_comb begin
      cur_x = CW'(req_payload.cursor_in);
      s_raw = cur_x;
      if (flags_ff[FLAG_OFFSET]) begin
         s_raw = CW'(offset_ff);
      end
      if (flags_ff[FLAG_DISTANCE]) begin
         s_raw = cur_x + CW'(dist_ff);
      end
      s_clip = clip(s_raw);
      d_end  = clip(s_clip + CW'(depth_ff));
      w_end  = clip(cur_x + CW'(within_ff));
      e_sel  = CW'(MAX_PAYLOAD);
      if (flags_ff[FLAG_DEPTH] && d_end < e_sel) begin
         e_sel = d_end;
      end
      if (flags_ff[FLAG_WITHIN] && w_end < e_sel) begin
         e_sel = w_end;
      end
   end

   // stage A next state, plus the inputs of the stage B registers
   always_comb begin
      load_idx_in = load_idx_ff;
      pos_in      = pos_ff;
      ws_in       = ws_ff;
      we_in       = we_ff;
      pc_in       = pc_ff;
      b_valid_in  = b_valid_ff;
      b_last_in   = b_last_ff;
      b_first_in  = b_first_ff;
      b_check_in  = b_check_ff;
      b_endpos_in = b_endpos_ff;

      if (load_go) begin
         if (load_idx_ff < LEN_W'(MAX_PATTERN)) begin
            load_idx_in = load_idx_ff + LEN_W'(1);
         end
         if (req_payload.last) begin
            load_idx_in = '0;
         end
      end

      if (!stall) begin
         b_valid_in = pay_go;
      end

      if (pay_go) begin
         if (pos_ff == '0) begin
            ws_in = POS_W'(s_clip);
            we_in = POS_W'(e_sel);
            pc_in = req_payload.cursor_in;
         end
         b_last_in   = req_payload.last;
         b_first_in  = (pos_ff == '0);
         b_check_in  = shift_go;
         b_endpos_in = pos_ff + POS_W'(1);
         if (req_payload.last) begin
            pos_in = '0;
         end else if (shift_go) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // cell row
   assign all_eq = &eq_vec;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      cell_ctrl_type ctrl;
      logic [7:0]    nbr;

      always_comb begin
         ctrl.load_we = load_go && (load_idx_ff == LEN_W'(j));
         ctrl.shift   = shift_go;
         ctrl.tail    = (eff_len == LEN_W'(j + 1));
         ctrl.active  = (LEN_W'(j) < eff_len);
         ctrl.nocase  = flags_ff[FLAG_NOCASE];
      end

      if (j < MAX_PATTERN - 1) begin : g_mid
         assign nbr = win_byte[j+1];
      end else begin : g_end
         assign nbr = req_payload.data_byte;
      end

      wcm_cell u_cell (
         .clock (clock),
         .ctrl  (ctrl),
         .din   (req_payload.data_byte),
         .nbr   (nbr),
         .wout  (win_byte[j]),
         .eq    (eq_vec[j])
      );
   end

   // stage B: compare result, first match and output
   always_comb begin
      lo_bound = CW'(ws_ff) + CW'(eff_len);
      win_ok   = (CW'(b_endpos_ff) >= lo_bound) && (b_endpos_ff <= we_ff);
      mf_eff   = b_first_ff ? 1'b0 : mf_ff;
      me_eff   = b_first_ff ? '0 : me_ff;
      hit      = b_check_ff && !mf_eff && (eff_len != '0) && win_ok && all_eq;

      mf_in          = mf_ff;
      me_in          = me_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      if (b_valid_ff && !stall) begin
         mf_in = mf_eff || hit;
         me_in = hit ? b_endpos_ff : me_eff;
         if (b_last_ff) begin
            rsp_valid_in = 1'b1;
            if (eff_len == '0) begin
               rsp_payload_in.matched    = 1'b1;
               rsp_payload_in.cursor_out = pc_ff;
            end else if (mf_in) begin
               rsp_payload_in.matched    = 1'b1;
               rsp_payload_in.cursor_out = POS12_W'(me_in);
            end else begin
               rsp_payload_in.matched    = 1'b0;
               rsp_payload_in.cursor_out = pc_ff;
            end
            mf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         offset_ff    <= '0;
         dist_ff      <= '0;
         depth_ff     <= '0;
         within_ff    <= '0;
         plen_ff      <= '0;
         load_idx_ff  <= '0;
         pos_ff       <= '0;
         ws_ff        <= '0;
         we_ff        <= '0;
         pc_ff        <= '0;
         b_valid_ff   <= 1'b0;
         mf_ff        <= 1'b0;
         me_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MODIFIER_FLAGS:    flags_ff  <= csr_wdata[FLAGS_W-1:0];
               CSR_START_OFFSET:      offset_ff <= csr_wdata;
               CSR_RELATIVE_DISTANCE: dist_ff   <= csr_wdata;
               CSR_DEPTH_LIMIT:       depth_ff  <= csr_wdata;
               CSR_WITHIN_LIMIT:      within_ff <= csr_wdata;
               CSR_PATTERN_LENGTH:    plen_ff   <= csr_wdata[PLEN_W-1:0];
               default: ;
            endcase
         end
         load_idx_ff  <= load_idx_in;
         pos_ff       <= pos_in;
         ws_ff        <= ws_in;
         we_ff        <= we_in;
         pc_ff        <= pc_in;
         b_valid_ff   <= b_valid_in;
         mf_ff        <= mf_in;
         me_ff        <= me_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      b_last_ff      <= b_last_in;
      b_first_ff     <= b_first_in;
      b_check_ff     <= b_check_in;
      b_endpos_ff    <= b_endpos_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import wcm_pkg::*;

   localparam int MAX_PATTERN = 32;
   localparam int MAX_PAYLOAD = 2048;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 6;
   localparam int MAX_GAP = 20;
   localparam int PHASE_ITEMS = 100;
   localparam int MAX_REPORTS = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   localparam logic [FLAGS_W-1:0] FL_NONE     = '0;
   localparam logic [FLAGS_W-1:0] FL_OFFSET   = FLAGS_W'(1 << FLAG_OFFSET);
   localparam logic [FLAGS_W-1:0] FL_DISTANCE = FLAGS_W'(1 << FLAG_DISTANCE);
   localparam logic [FLAGS_W-1:0] FL_DEPTH    = FLAGS_W'(1 << FLAG_DEPTH);
   localparam logic [FLAGS_W-1:0] FL_WITHIN   = FLAGS_W'(1 << FLAG_WITHIN);
   localparam logic [FLAGS_W-1:0] FL_NOCASE   = FLAGS_W'(1 << FLAG_NOCASE);
   localparam logic [FLAGS_W-1:0] FL_ALL      = '1;

   typedef logic [7:0] byte_queue_type[$];

   typedef struct {
      logic [FLAGS_W-1:0]    flags;
      logic [CSR_DATA_W-1:0] start_pos;
      logic [CSR_DATA_W-1:0] rel_start;
      logic [CSR_DATA_W-1:0] depth_len;
      logic [CSR_DATA_W-1:0] within_len;
      logic [PLEN_W-1:0]     pat_len;
   } window_setup_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   windowed_content_matcher #(
      .MAX_PATTERN(MAX_PATTERN),
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // matcher model state and its copy of the registers
   logic [7:0]          pat_bytes[MAX_PATTERN];
   logic [7:0]          window_hist[MAX_PATTERN];
   int unsigned         pkt_pos = 0;
   int unsigned         load_ptr = 0;
   int unsigned         win_first = 0;
   int unsigned         win_end = 0;
   int unsigned         pkt_cursor = 0;
   int unsigned         hit_end = 0;
   bit                  hit = 1'b0;
   logic [FLAGS_W-1:0]  cfg_flags = '0;
   logic [POS12_W-1:0]  cfg_start = '0;
   logic [POS12_W-1:0]  cfg_rel = '0;
   logic [POS12_W-1:0]  cfg_depth = '0;
   logic [POS12_W-1:0]  cfg_within = '0;
   logic [PLEN_W-1:0]   cfg_plen = '0;

   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      items_sent = 0;
   int      send_pct = 0;
   int      stall_pct = 0;

   initial begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pat_bytes[k] = '0;
         window_hist[k] = '0;
      end
   end

   function automatic int unsigned clip_pos(input int unsigned v);
      return (v > MAX_PAYLOAD) ? MAX_PAYLOAD : v;
   endfunction

   function automatic int unsigned active_len();
      return (cfg_plen > MAX_PATTERN) ? MAX_PATTERN : cfg_plen;
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
   endfunction

   function automatic logic [7:0] random_case(input logic [7:0] c);
      logic [7:0] low;
      low = fold_case(c);
      return (low >= "a" && low <= "z" && $urandom_range(1)) ? c ^ 8'h20 : c;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_MODIFIER_FLAGS:    cfg_flags = value[FLAGS_W-1:0];
         CSR_START_OFFSET:      cfg_start = value;
         CSR_RELATIVE_DISTANCE: cfg_rel = value;
         CSR_DEPTH_LIMIT:       cfg_depth = value;
         CSR_WITHIN_LIMIT:      cfg_within = value;
         CSR_PATTERN_LENGTH:    cfg_plen = value[PLEN_W-1:0];
         default: ;
      endcase
   endfunction

   // advance the matcher model by one item; returns 1 when a result is due
   function automatic bit predict_match(input req_type item, output rsp_type rsp);
      int unsigned cur, lo, hi, len, endpos;
      int k;
      bit same;
      logic [7:0] h, n;
      rsp = '0;
      len = active_len();
      if (item.cmd == CMD_LOAD) begin
         if (load_ptr < MAX_PATTERN) begin
            pat_bytes[load_ptr] = item.data_byte;
            load_ptr++;
         end
         if (item.last)
            load_ptr = 0;
         return 1'b0;
      end
      if (pkt_pos == 0) begin
         cur = item.cursor_in;
         lo = cur;
         hi = MAX_PAYLOAD;
         pkt_cursor = cur;
         if (cfg_flags[FLAG_OFFSET])
            lo = cfg_start;
         if (cfg_flags[FLAG_DISTANCE])
            lo = cur + cfg_rel;
         lo = clip_pos(lo);
         if (cfg_flags[FLAG_DEPTH] && clip_pos(lo + cfg_depth) < hi)
            hi = clip_pos(lo + cfg_depth);
         if (cfg_flags[FLAG_WITHIN] && clip_pos(cur + cfg_within) < hi)
            hi = clip_pos(cur + cfg_within);
         win_first = lo;
         win_end = hi;
         hit = 1'b0;
         hit_end = 0;
      end
      if (pkt_pos < MAX_PAYLOAD) begin
         endpos = pkt_pos + 1;
         for (k = 0; k < MAX_PATTERN - 1; k++)
            window_hist[k] = window_hist[k + 1];
         window_hist[MAX_PATTERN - 1] = item.data_byte;
         if (!hit && len > 0 && endpos >= len && endpos - len >= win_first &&
             endpos <= win_end) begin
            same = 1'b1;
            for (k = 0; k < len; k++) begin
               h = window_hist[MAX_PATTERN - len + k];
               n = pat_bytes[k];
               if (cfg_flags[FLAG_NOCASE]) begin
                  h = fold_case(h);
                  n = fold_case(n);
               end
               if (h != n)
                  same = 1'b0;
            end
            if (same) begin
               hit = 1'b1;
               hit_end = endpos;
            end
         end
         pkt_pos = endpos;
      end
      if (!item.last)
         return 1'b0;
      rsp.matched = (len == 0) || hit;
      rsp.cursor_out = (len != 0 && hit) ? hit_end[POS12_W-1:0] : pkt_cursor[POS12_W-1:0];
      pkt_pos = 0;
      hit = 1'b0;
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch in %0s: expected %0d, actual %0d at %0t ns", what, want, got,
                  $time);
   endtask

   // result side: compare each accepted item, then pick the next ready level
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            note_mismatch("unexpected result, cursor_out", -1, rsp_payload.cursor_out);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.matched !== want.matched)
               note_mismatch("matched", want.matched, rsp_payload.matched);
            if (rsp_payload.cursor_out !== want.cursor_out)
               note_mismatch("cursor_out", want.cursor_out, rsp_payload.cursor_out);
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin : watchdog
      int unsigned n;
      for (n = 0; n < CYCLE_LIMIT; n++)
         @(posedge clock);
      $display("status: fail");
      $finish;
   end

   function automatic req_type make_item(input logic cmd, input logic [7:0] data,
                                         input logic last, input logic [POS12_W-1:0] cur);
      req_type it;
      it.cmd = cmd;
      it.data_byte = data;
      it.last = last;
      it.cursor_in = cur;
      return it;
   endfunction

   function automatic byte_queue_type text_bytes(input string s);
      byte_queue_type q;
      int k;
      for (k = 0; k < s.len(); k++)
         q = {q, 8'(s[k])};
      return q;
   endfunction

   function automatic window_setup_type make_setup(input logic [FLAGS_W-1:0] flags,
                                                   input int start_pos, input int rel_start,
                                                   input int depth_len, input int within_len,
                                                   input int pat_len);
      window_setup_type s;
      s.flags = flags;
      s.start_pos = CSR_DATA_W'(start_pos);
      s.rel_start = CSR_DATA_W'(rel_start);
      s.depth_len = CSR_DATA_W'(depth_len);
      s.within_len = CSR_DATA_W'(within_len);
      s.pat_len = PLEN_W'(pat_len);
      return s;
   endfunction

   // called at a rising edge; leaves valid high when the next item follows at once
   task automatic send_item(input req_type item);
      rsp_type r;
      int gap;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (predict_match(item, r))
         expected_rsps = {expected_rsps, r};
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_pattern(input byte_queue_type bytes);
      int k;
      for (k = 0; k < bytes.size(); k++)
         send_item(make_item(CMD_LOAD, bytes[k], k == bytes.size() - 1, POS12_W'($urandom)));
   endtask

   // cursor_in only counts on the first byte; scramble it on the rest
   task automatic send_packet(input byte_queue_type bytes, input logic [POS12_W-1:0] cur,
                              input int noise_pct);
      int k;
      for (k = 0; k < bytes.size(); k++) begin
         if ($urandom_range(99) < noise_pct)
            send_item(make_item(CMD_LOAD, 8'($urandom), $urandom_range(9) == 0,
                                POS12_W'($urandom)));
         send_item(make_item(CMD_PAYLOAD, bytes[k], k == bytes.size() - 1,
                             (k == 0) ? cur : POS12_W'($urandom)));
      end
   endtask

   // advance at least one edge, then until every expected result is back
   task automatic wait_results();
      do @(posedge clock); while (expected_rsps.size() != 0);
   endtask

   // drop valid, drain results and let a trailing load finish inside the block
   task automatic settle();
      req_valid <= 1'b0;
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      apply_csr(index, value);
   endtask

   task automatic configure(input window_setup_type s);
      settle();
      write_csr(CSR_MODIFIER_FLAGS, {7'($urandom), s.flags});
      write_csr(CSR_START_OFFSET, s.start_pos);
      write_csr(CSR_RELATIVE_DISTANCE, s.rel_start);
      write_csr(CSR_DEPTH_LIMIT, s.depth_len);
      write_csr(CSR_WITHIN_LIMIT, s.within_len);
      write_csr(CSR_PATTERN_LENGTH, {6'($urandom), s.pat_len});
      if ($urandom_range(3) == 0)
         write_csr(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_bound();
      case ($urandom_range(9))
         0: return '0;
         1: return CSR_DATA_W'(MAX_PAYLOAD);
         2: return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(12));
      endcase
   endfunction

   function automatic window_setup_type random_setup();
      window_setup_type s;
      s.flags = FLAGS_W'($urandom);
      s.start_pos = random_bound();
      s.rel_start = random_bound();
      s.depth_len = random_bound();
      s.within_len = random_bound();
      case ($urandom_range(9))
         0: s.pat_len = '0;
         1: s.pat_len = PLEN_W'($urandom_range(33, 63));
         2: s.pat_len = PLEN_W'(MAX_PATTERN);
         default: s.pat_len = PLEN_W'($urandom_range(1, 4));
      endcase
      return s;
   endfunction

   function automatic byte_queue_type random_pattern();
      byte_queue_type q;
      int n, k;
      n = ($urandom_range(5) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
      for (k = 0; k < n; k++)
         q = {q, ($urandom_range(2) ? random_case("a" + 8'($urandom_range(2)))
                                    : 8'($urandom))};
      return q;
   endfunction

   // about half pattern-like bytes, often with the whole pattern planted somewhere
   function automatic byte_queue_type random_payload();
      byte_queue_type q;
      int n, len, at, k;
      n = ($urandom_range(4) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      len = active_len();
      for (k = 0; k < n; k++)
         q = {q, ($urandom_range(1) ? random_case(pat_bytes[$urandom_range(3)])
                                    : 8'($urandom))};
      if (len > 0 && len <= n && $urandom_range(1)) begin
         at = $urandom_range(n - len);
         for (k = 0; k < len; k++)
            q[at + k] = random_case(pat_bytes[k]);
      end
      return q;
   endfunction

   function automatic logic [POS12_W-1:0] random_cursor();
      case ($urandom_range(6))
         0: return POS12_W'($urandom);
         1: return POS12_W'(MAX_PAYLOAD);
         default: return POS12_W'($urandom_range(12));
      endcase
   endfunction

   // registers still at reset values: empty pattern matches, cursor passes through
   task automatic test_empty_pattern();
      send_packet(text_bytes("xyz"), '1, 0);
      send_packet(text_bytes("q"), '0, 0);
   endtask

   // overflow loads must not wrap onto the first entries
   task automatic test_pattern_load();
      byte_queue_type q;
      q = text_bytes("ab");
      repeat (MAX_PATTERN - 2) q = {q, 8'($urandom)};
      q = {q, 8'("z")};
      q = {q, 8'("z")};
      load_pattern(q);
      configure(make_setup(FL_NONE, 0, 0, 0, 0, 2));
      send_packet(text_bytes("zab"), 12'd7, 0);
   endtask

   task automatic test_case_folding();
      configure(make_setup(FL_NOCASE, 0, 0, 0, 0, 2));
      load_pattern(text_bytes("Ab"));
      send_packet(text_bytes("xaB"), '0, 0);
      load_pattern(text_bytes("Z["));
      send_packet(text_bytes("z["), '0, 0);
      send_packet(text_bytes("z{"), '0, 0);
      configure(make_setup(FL_NONE, 0, 0, 0, 0, 2));
      send_packet(text_bytes("z["), '0, 0);
      send_packet(text_bytes("Z["), '0, 0);
   endtask

   task automatic test_long_pattern_length();
      byte_queue_type q;
      int k;
      configure(make_setup(FL_NONE, 0, 0, 0, 0, 63));
      for (k = 0; k < MAX_PATTERN; k++)
         q = {q, pat_bytes[k]};
      send_packet(q, 12'd3, 0);
   endtask

   task automatic test_leftmost_match();
      load_pattern(text_bytes("ab"));
      configure(make_setup(FL_NONE, 0, 0, 0, 0, 2));
      send_packet(text_bytes("xabxab"), 12'd1, 0);
   endtask

   task automatic test_window_bounds();
      byte_queue_type q;
      q = text_bytes("ababab");
      configure(make_setup(FL_OFFSET, 2, 0, 0, 0, 2));
      send_packet(q, '0, 0);
      // distance wins over offset
      configure(make_setup(FL_OFFSET | FL_DISTANCE, 0, 2, 0, 0, 2));
      send_packet(q, 12'd1, 0);
      configure(make_setup(FL_OFFSET | FL_DEPTH, 1, 0, 3, 0, 2));
      send_packet(q, '0, 0);
      configure(make_setup(FL_OFFSET | FL_DEPTH, 1, 0, 2, 0, 2));
      send_packet(q, '0, 0);
      configure(make_setup(FL_WITHIN, 0, 0, 0, 1, 2));
      send_packet(q, '0, 0);
      // inverted window
      configure(make_setup(FL_OFFSET | FL_DEPTH | FL_WITHIN, 4, 0, 2, 1, 2));
      send_packet(q, '0, 0);
      configure(make_setup(FL_ALL, 4095, 4095, 4095, 4095, 2));
      send_packet(q, '1, 0);
      configure(make_setup(FL_ALL, 4095, 4095, 0, 0, 0));
      send_packet(q, 12'd2048, 0);
   endtask

   // a load between payload bytes changes the pattern for the rest of the packet
   task automatic test_live_pattern_update();
      configure(make_setup(FL_NONE, 0, 0, 0, 0, 2));
      load_pattern(text_bytes("ab"));
      send_item(make_item(CMD_PAYLOAD, "c", 1'b0, 12'd5));
      load_pattern(text_bytes("cd"));
      send_item(make_item(CMD_PAYLOAD, "d", 1'b1, POS12_W'($urandom)));
   endtask

   // a hit ending exactly at the payload limit counts, one past it does not
   task automatic test_long_payload();
      byte_queue_type q;
      configure(make_setup(FL_NONE, 0, 0, 0, 0, 2));
      load_pattern(text_bytes("ab"));
      repeat (MAX_PAYLOAD + 2) q = {q, 8'h00};
      q[MAX_PAYLOAD - 2] = "a";
      q[MAX_PAYLOAD - 1] = "b";
      send_packet(q, '0, 0);
      q[MAX_PAYLOAD - 2] = 8'h00;
      q[MAX_PAYLOAD - 1] = "a";
      q[MAX_PAYLOAD] = "b";
      send_packet(q, '0, 0);
   endtask

   task automatic test_random_traffic(input int send_idle, input int recv_stall,
                                      input bit pause_once);
      int first_item;
      bit paused;
      send_pct = send_idle;
      stall_pct = recv_stall;
      first_item = items_sent;
      paused = 1'b0;
      while (items_sent - first_item < PHASE_ITEMS) begin
         configure(random_setup());
         load_pattern(random_pattern());
         repeat ($urandom_range(3, 8)) begin
            send_packet(random_payload(), random_cursor(), 5);
            if (pause_once && !paused) begin
               // hold off until every result is back
               req_valid <= 1'b0;
               wait_results();
               paused = 1'b1;
            end
         end
      end
   endtask

   initial begin
      send_pct = 15;
      stall_pct = 15;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_pattern();
      test_pattern_load();
      test_case_folding();
      test_long_pattern_length();
      test_leftmost_match();
      test_window_bounds();
      test_live_pattern_update();
      send_pct = 0;
      stall_pct = 0;
      test_long_payload();
      test_random_traffic(0, 0, 1'b0);
      test_random_traffic(54, 0, 1'b1);
      test_random_traffic(0, 54, 1'b0);
      test_random_traffic(15, 15, 1'b0);
      settle();
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
